[hw/rtl/u8n1_pkg.sv]
`default_nettype none

package u8n1_pkg;

  // Defaults for the top-level parameters
  localparam int DATA_BITS_DEF    = 8;
  localparam int PERIOD_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int BYTE_W     = 8;
  localparam int CFG_DATA_W = 16;
  localparam int ERR_W      = 16;

  localparam logic [CFG_DATA_W-1:0] BIT_PERIOD_RST = 16'd16;
  localparam logic [ERR_W-1:0]      ERR_MAX        = {ERR_W{1'b1}};

  // Request codes
  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_SEND = 2'd1,
    REQ_RECV = 2'd2
  } req_type_t;

  // Request status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RX_EMPTY = 2'd1,
    ST_TX_BUSY  = 2'd2
  } req_status_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_BIT_PERIOD = 1'b0,
    CFG_RX_IRQ_EN  = 1'b1
  } cfg_index_t;

endpackage

`default_nettype wire

[hw/rtl/uart_8n1_transceiver_unit.sv]
`default_nettype none

// Single-buffered 8N1 UART driven by request items. A tick request samples
// in_rx_line and advances both bit timers by one; a send request loads a
// byte when the transmitter is idle (else status busy); a receive request
// pops the held byte (else status empty). Every request yields exactly one
// response with the line and flag state after the request. All state
// updates on the clock edge at which a request is accepted and the
// response is held in an output register, so a new request is taken
// every cycle as long as the response side keeps up. bit_period (cfg
// index 0) sets ticks per bit, the receiver samples the start bit after
// half of it; rx_irq_enable (cfg index 1) gates the receive interrupt.
// Configuration writes are always taken and must only be issued while idle.
module uart_8n1_transceiver_unit
  import u8n1_pkg::*;
#(
  parameter int DATA_BITS    = DATA_BITS_DEF,
  parameter int PERIOD_WIDTH = PERIOD_WIDTH_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  // Request channel
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  [1:0]            in_req_type,
  input  wire                   in_rx_line,
  input  wire  [BYTE_W-1:0]     in_tx_byte,
  // Response channel
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic                  out_tx_line,
  output logic [BYTE_W-1:0]     out_rx_byte,
  output logic [1:0]            out_req_status,
  output logic                  out_rx_ready,
  output logic                  out_tx_empty,
  output logic                  out_tx_complete,
  output logic [ERR_W-1:0]      out_framing_errors,
  output logic                  out_rx_irq,
  // Configuration write channel
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire                   cfg_index,
  input  wire  [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(DATA_BITS + 2);
  localparam int PW    = PERIOD_WIDTH;

  // Configuration
  logic [CFG_DATA_W-1:0] bit_period_r;
  logic                  rx_irq_en_r;

  // Receiver state
  logic [IDX_W-1:0]     rx_bit_idx_r,  rx_bit_idx_nxt;
  logic                 rx_active_r,   rx_active_nxt;
  logic [PW-1:0]        rx_tick_cnt_r, rx_tick_cnt_nxt;
  logic [DATA_BITS-1:0] rx_shift_r,    rx_shift_nxt;
  logic [BYTE_W-1:0]    rx_hold_r,     rx_hold_nxt;
  logic                 rx_full_r,     rx_full_nxt;
  logic                 rx_prev_r,     rx_prev_nxt;
  logic [ERR_W-1:0]     error_cnt_r,   error_cnt_nxt;

  // Transmitter state
  logic [IDX_W-1:0]     tx_bit_idx_r,  tx_bit_idx_nxt;
  logic [PW-1:0]        tx_tick_cnt_r, tx_tick_cnt_nxt;
  logic [DATA_BITS-1:0] tx_shift_r,    tx_shift_nxt;
  logic                 tx_empty_r,    tx_empty_nxt;
  logic                 tx_cmpl_r,     tx_cmpl_nxt;
  logic                 tx_line_r,     tx_line_nxt;

  // Response register
  logic                 out_valid_r,   out_valid_nxt;
  logic [BYTE_W-1:0]    out_rx_byte_r;
  logic [1:0]           out_status_r;
  logic                 out_irq_r;

  logic                 accept;
  req_type_t            req;
  req_status_t          status;
  logic [BYTE_W-1:0]    rbyte;
  logic                 irq;
  logic [PW-1:0]        period;
  logic [PW-1:0]        rx_target;
  logic [PW-1:0]        tx_target;
  logic [PW-1:0]        rx_cnt_inc;
  logic [PW-1:0]        tx_cnt_inc;
  logic [DATA_BITS-1:0] rx_shift_set;
  logic                 tx_bit;

  assign accept    = in_valid && in_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign req       = req_type_t'(in_req_type);

  // Bit timing targets, never below one tick
  always_comb begin
    period    = PW'(bit_period_r);
    rx_target = (rx_bit_idx_r == '0) ? (period >> 1) : period;
    if (rx_target == '0) begin
      rx_target = PW'(1);
    end
    tx_target = (period == '0) ? PW'(1) : period;
    rx_cnt_inc = rx_tick_cnt_r + PW'(1);
    tx_cnt_inc = tx_tick_cnt_r + PW'(1);
  end

  // Insert the sampled bit and pick the bit to send
  always_comb begin
    tx_bit = 1'b0;
    for (int b = 0; b < DATA_BITS; b++) begin
      rx_shift_set[b] = rx_shift_r[b] |
                        (in_rx_line && (rx_bit_idx_r == IDX_W'(b + 1)));
      tx_bit = tx_bit | (tx_shift_r[b] && (tx_bit_idx_r == IDX_W'(b + 1)));
    end
  end

  // Next state for one request
  always_comb begin
    rx_bit_idx_nxt  = rx_bit_idx_r;
    rx_active_nxt   = rx_active_r;
    rx_tick_cnt_nxt = rx_tick_cnt_r;
    rx_shift_nxt    = rx_shift_r;
    rx_hold_nxt     = rx_hold_r;
    rx_full_nxt     = rx_full_r;
    rx_prev_nxt     = rx_prev_r;
    error_cnt_nxt   = error_cnt_r;
    tx_bit_idx_nxt  = tx_bit_idx_r;
    tx_tick_cnt_nxt = tx_tick_cnt_r;
    tx_shift_nxt    = tx_shift_r;
    tx_empty_nxt    = tx_empty_r;
    tx_cmpl_nxt     = tx_cmpl_r;
    tx_line_nxt     = tx_line_r;
    status          = ST_OK;
    rbyte           = '0;
    irq             = 1'b0;

    if (accept) begin
      unique case (req)
        REQ_TICK: begin
          // Receiver: hunt for start edge, else time the current bit
          if (!rx_active_r) begin
            if (rx_prev_r && !in_rx_line) begin
              if (!rx_full_r) begin
                rx_active_nxt   = 1'b1;
                rx_tick_cnt_nxt = '0;
                rx_bit_idx_nxt  = '0;
              end else begin
                irq = rx_irq_en_r;
              end
            end
          end else if (rx_cnt_inc >= rx_target) begin
            rx_tick_cnt_nxt = '0;
            if (rx_bit_idx_r == '0) begin
              if (in_rx_line) begin
                // Bad start bit: count it and drop the frame
                if (error_cnt_r != ERR_MAX) begin
                  error_cnt_nxt = error_cnt_r + ERR_W'(1);
                end
                rx_active_nxt  = 1'b0;
                rx_bit_idx_nxt = '0;
                rx_shift_nxt   = '0;
              end else begin
                rx_bit_idx_nxt = IDX_W'(1);
              end
            end else if (rx_bit_idx_r == IDX_W'(DATA_BITS)) begin
              rx_hold_nxt    = BYTE_W'(rx_shift_set);
              rx_full_nxt    = 1'b1;
              rx_shift_nxt   = '0;
              rx_active_nxt  = 1'b0;
              rx_bit_idx_nxt = '0;
              irq            = rx_irq_en_r;
            end else begin
              rx_shift_nxt   = rx_shift_set;
              rx_bit_idx_nxt = rx_bit_idx_r + IDX_W'(1);
            end
          end else begin
            rx_tick_cnt_nxt = rx_cnt_inc;
          end
          rx_prev_nxt = in_rx_line;

          // Transmitter: advance one bit per period until the stop bit
          if (!tx_cmpl_r) begin
            if (tx_cnt_inc < tx_target) begin
              tx_tick_cnt_nxt = tx_cnt_inc;
            end else begin
              tx_tick_cnt_nxt = '0;
              if (tx_bit_idx_r == '0) begin
                tx_empty_nxt   = 1'b1;
                tx_line_nxt    = 1'b0;
                tx_bit_idx_nxt = IDX_W'(1);
              end else if (tx_bit_idx_r <= IDX_W'(DATA_BITS)) begin
                tx_line_nxt    = tx_bit;
                tx_bit_idx_nxt = tx_bit_idx_r + IDX_W'(1);
              end else begin
                tx_line_nxt    = 1'b1;
                tx_cmpl_nxt    = 1'b1;
                tx_bit_idx_nxt = '0;
              end
            end
          end
        end
        REQ_SEND: begin
          if (tx_empty_r && tx_cmpl_r) begin
            tx_shift_nxt    = DATA_BITS'(in_tx_byte);
            tx_empty_nxt    = 1'b0;
            tx_cmpl_nxt     = 1'b0;
            tx_tick_cnt_nxt = '0;
            tx_bit_idx_nxt  = '0;
          end else begin
            status = ST_TX_BUSY;
          end
        end
        REQ_RECV: begin
          if (rx_full_r) begin
            rbyte       = rx_hold_r;
            rx_full_nxt = 1'b0;
          end else begin
            status = ST_RX_EMPTY;
          end
        end
        default: begin
          // Unused request code: no effect
        end
      endcase
    end
  end

  // Response valid: set on accept, drop once taken
  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r  <= BIT_PERIOD_RST;
      rx_irq_en_r   <= 1'b0;
      rx_bit_idx_r  <= '0;
      rx_active_r   <= 1'b0;
      rx_tick_cnt_r <= '0;
      rx_shift_r    <= '0;
      rx_hold_r     <= '0;
      rx_full_r     <= 1'b0;
      rx_prev_r     <= 1'b1;
      error_cnt_r   <= '0;
      tx_bit_idx_r  <= '0;
      tx_tick_cnt_r <= '0;
      tx_shift_r    <= '0;
      tx_empty_r    <= 1'b1;
      tx_cmpl_r     <= 1'b1;
      tx_line_r     <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_BIT_PERIOD: bit_period_r <= cfg_data;
          CFG_RX_IRQ_EN:  rx_irq_en_r  <= cfg_data[0];
        endcase
      end
      rx_bit_idx_r  <= rx_bit_idx_nxt;
      rx_active_r   <= rx_active_nxt;
      rx_tick_cnt_r <= rx_tick_cnt_nxt;
      rx_shift_r    <= rx_shift_nxt;
      rx_hold_r     <= rx_hold_nxt;
      rx_full_r     <= rx_full_nxt;
      rx_prev_r     <= rx_prev_nxt;
      error_cnt_r   <= error_cnt_nxt;
      tx_bit_idx_r  <= tx_bit_idx_nxt;
      tx_tick_cnt_r <= tx_tick_cnt_nxt;
      tx_shift_r    <= tx_shift_nxt;
      tx_empty_r    <= tx_empty_nxt;
      tx_cmpl_r     <= tx_cmpl_nxt;
      tx_line_r     <= tx_line_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Response payload: hold until the next accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      out_rx_byte_r <= rbyte;
      out_status_r  <= status;
      out_irq_r     <= irq;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_tx_line        = tx_line_r;
  assign out_rx_byte        = out_rx_byte_r;
  assign out_req_status     = out_status_r;
  assign out_rx_ready       = rx_full_r;
  assign out_tx_empty       = tx_empty_r;
  assign out_tx_complete    = tx_cmpl_r;
  assign out_framing_errors = error_cnt_r;
  assign out_rx_irq         = out_irq_r;

`ifndef ASSERT_OFF
  // A full buffer never coexists with an active reception
  a_rx_full_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(rx_active_r && rx_full_r))
    else $error("receiver active while buffer full");

  // Framing error count never goes down
  a_err_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (error_cnt_r >= $past(error_cnt_r)))
    else $error("framing error count decreased");

  // A send taken by an idle transmitter starts a frame
  a_send_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && req == REQ_SEND && tx_empty_r && tx_cmpl_r)
      |=> (!tx_cmpl_r && !tx_empty_r))
    else $error("send request did not start transmitter");

  // Receive bit index stays within the frame
  a_rx_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    rx_bit_idx_r <= IDX_W'(DATA_BITS))
    else $error("receive bit index out of range");
`endif

endmodule

`default_nettype wire

[dv/uart_resp_checker.sv]
module uart_resp_checker
  import u8n1_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire                  in_ready,
  input  wire [1:0]            in_req_type,
  input  wire                  in_rx_line,
  input  wire [BYTE_W-1:0]     in_tx_byte,
  input  wire                  out_valid,
  input  wire                  out_ready,
  input  wire                  out_tx_line,
  input  wire [BYTE_W-1:0]     out_rx_byte,
  input  wire [1:0]            out_req_status,
  input  wire                  out_rx_ready,
  input  wire                  out_tx_empty,
  input  wire                  out_tx_complete,
  input  wire [ERR_W-1:0]      out_framing_errors,
  input  wire                  out_rx_irq,
  input  wire                  cfg_valid,
  input  wire                  cfg_ready,
  input  wire                  cfg_index,
  input  wire [CFG_DATA_W-1:0] cfg_data,
  output int                   fail_cnt,
  output int                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Keep the log short when responses keep arriving with nothing pending
  localparam int REPORT_CAP = 40;

  // Line and flag state reported for one request
  typedef struct packed {
    logic              tx_line;
    logic [BYTE_W-1:0] rx_byte;
    logic [1:0]        status;
    logic              rx_ready;
    logic              tx_empty;
    logic              tx_complete;
    logic [ERR_W-1:0]  errors;
    logic              irq;
  } uart_resp_t;

  uart_resp_t resp_due[$];

  // Register copies
  logic [CFG_DATA_W-1:0] period_q;
  logic                  irq_en_q;

  // Receiver state
  logic [3:0]            rx_idx;
  logic                  rx_busy;
  logic [CFG_DATA_W-1:0] rx_cnt;
  logic [BYTE_W-1:0]     rx_sr;
  logic [BYTE_W-1:0]     rx_buf;
  logic                  rx_has;
  logic                  rx_last;
  logic [ERR_W-1:0]      err_cnt;

  // Transmitter state
  logic [3:0]            tx_idx;
  logic [CFG_DATA_W-1:0] tx_cnt;
  logic [BYTE_W-1:0]     tx_sr;
  logic                  tx_emp;
  logic                  tx_cmp;
  logic                  tx_lvl;

  // Advance the receiver by one tick; return the interrupt pulse
  function automatic logic rx_advance(input logic ln);
    logic                  fire;
    logic [CFG_DATA_W-1:0] goal;
    fire = 1'b0;
    if (!rx_busy) begin
      // Start on a falling edge, or re-pulse the interrupt while full
      if (rx_last && !ln) begin
        if (!rx_has) begin
          rx_busy = 1'b1;
          rx_cnt  = '0;
          rx_idx  = '0;
        end else if (irq_en_q) begin
          fire = 1'b1;
        end
      end
    end else begin
      goal = (rx_idx == 4'd0) ? (period_q >> 1) : period_q;
      if (goal == '0) goal = CFG_DATA_W'(1);
      rx_cnt = rx_cnt + 1'b1;
      if (rx_cnt >= goal) begin
        rx_cnt = '0;
        if (rx_idx == 4'd0) begin
          // Start bit read high: count it and drop the frame
          if (ln) begin
            if (err_cnt != ERR_MAX) err_cnt = err_cnt + 1'b1;
            rx_busy = 1'b0;
            rx_idx  = '0;
            rx_sr   = '0;
          end else begin
            rx_idx = 4'd1;
          end
        end else begin
          rx_sr = rx_sr | (BYTE_W'(ln) << (rx_idx - 4'd1));
          if (rx_idx >= DATA_BITS_DEF) begin
            rx_buf  = rx_sr;
            rx_has  = 1'b1;
            rx_sr   = '0;
            rx_busy = 1'b0;
            rx_idx  = '0;
            if (irq_en_q) fire = 1'b1;
          end else begin
            rx_idx = rx_idx + 4'd1;
          end
        end
      end
    end
    rx_last = ln;
    return fire;
  endfunction

  // Advance the transmitter by one tick
  function automatic void tx_advance();
    logic [CFG_DATA_W-1:0] goal;
    goal = (period_q == '0) ? CFG_DATA_W'(1) : period_q;
    if (!tx_cmp) begin
      tx_cnt = tx_cnt + 1'b1;
      if (tx_cnt >= goal) begin
        tx_cnt = '0;
        if (tx_idx == 4'd0) begin
          tx_emp = 1'b1;
          tx_lvl = 1'b0;
          tx_idx = 4'd1;
        end else if (tx_idx <= DATA_BITS_DEF) begin
          tx_lvl = tx_sr[tx_idx - 4'd1];
          tx_idx = tx_idx + 4'd1;
        end else begin
          tx_lvl = 1'b1;
          tx_cmp = 1'b1;
          tx_idx = '0;
        end
      end
    end
  endfunction

  // Apply one request and return the state it reports
  function automatic uart_resp_t uart_step(input logic [1:0] rq, input logic ln,
                                           input logic [BYTE_W-1:0] bt);
    uart_resp_t r;
    r = '0;
    r.status = ST_OK;
    case (rq)
      REQ_TICK: begin
        r.irq = rx_advance(ln);
        tx_advance();
      end
      REQ_SEND: begin
        if (tx_emp && tx_cmp) begin
          tx_sr  = bt;
          tx_emp = 1'b0;
          tx_cmp = 1'b0;
          tx_cnt = '0;
          tx_idx = '0;
        end else begin
          r.status = ST_TX_BUSY;
        end
      end
      REQ_RECV: begin
        if (rx_has) begin
          r.rx_byte = rx_buf;
          rx_has    = 1'b0;
        end else begin
          r.status = ST_RX_EMPTY;
        end
      end
      default: ;
    endcase
    r.tx_line     = tx_lvl;
    r.rx_ready    = rx_has;
    r.tx_empty    = tx_emp;
    r.tx_complete = tx_cmp;
    r.errors      = err_cnt;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      fail_cnt++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // Track registers, predict each request and compare each response in order
  always @(posedge clk) begin
    uart_resp_t want;
    if (!rst_n) begin
      period_q = BIT_PERIOD_RST;
      irq_en_q = 1'b0;
      rx_idx   = '0;
      rx_busy  = 1'b0;
      rx_cnt   = '0;
      rx_sr    = '0;
      rx_buf   = '0;
      rx_has   = 1'b0;
      rx_last  = 1'b1;
      err_cnt  = '0;
      tx_idx   = '0;
      tx_cnt   = '0;
      tx_sr    = '0;
      tx_emp   = 1'b1;
      tx_cmp   = 1'b1;
      tx_lvl   = 1'b1;
      resp_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BIT_PERIOD) period_q = cfg_data;
        else irq_en_q = cfg_data[0];
      end
      if (out_valid && out_ready) begin
        if (resp_due.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_CAP) $error("response with no request outstanding");
        end else begin
          want = resp_due.pop_front();
          check_field("tx_line", want.tx_line, out_tx_line);
          check_field("rx_byte", want.rx_byte, out_rx_byte);
          check_field("req_status", want.status, out_req_status);
          check_field("rx_ready", want.rx_ready, out_rx_ready);
          check_field("tx_empty", want.tx_empty, out_tx_empty);
          check_field("tx_complete", want.tx_complete, out_tx_complete);
          check_field("framing_errors", want.errors, out_framing_errors);
          check_field("rx_irq", want.irq, out_rx_irq);
        end
      end
      if (in_valid && in_ready) resp_due.push_back(uart_step(in_req_type, in_rx_line, in_tx_byte));
    end
    outstanding = resp_due.size();
  end

endmodule

[dv/uart_8n1_transceiver_unit_tb.sv]
module uart_8n1_transceiver_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import u8n1_pkg::*;

  // Request code the block must treat as a no-op
  localparam logic [1:0] REQ_NOP = 2'd3;

  localparam int RANDOM_PHASES   = 4;
  localparam int PHASE_ITEMS     = 200;
  localparam int BAD_START_PAIRS = 100;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_req_type = REQ_TICK;
  logic                  in_rx_line  = 1'b1;
  logic [BYTE_W-1:0]     in_tx_byte  = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b1;
  logic                  out_tx_line;
  logic [BYTE_W-1:0]     out_rx_byte;
  logic [1:0]            out_req_status;
  logic                  out_rx_ready;
  logic                  out_tx_empty;
  logic                  out_tx_complete;
  logic [ERR_W-1:0]      out_framing_errors;
  logic                  out_rx_irq;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  cfg_index_t            cfg_index   = CFG_BIT_PERIOD;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  int fail_cnt;
  int outstanding;
  int item_cnt = 0;
  bit idle_on  = 1'b1;
  bit stall_on = 1'b1;

  uart_8n1_transceiver_unit dut (.*);

  uart_resp_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Bound the run
  initial begin
    #30ms;
    $display("[uart_8n1_transceiver_unit] ERROR");
    $finish;
  end

  // Throttle the response side in short bursts
  initial begin
    forever begin
      @(negedge clk);
      if (stall_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // Present one request, optionally after an idle burst, and hold until taken
  task automatic put_req(input logic [1:0] rq, input logic ln, input logic [BYTE_W-1:0] bt);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= rq;
    in_rx_line  <= ln;
    in_tx_byte  <= bt;
    do @(posedge clk); while (!in_ready);
    item_cnt++;
  endtask

  task automatic tick(input logic ln);
    put_req(REQ_TICK, ln, BYTE_W'($urandom));
  endtask

  // Now and then slip a send, a receive or a no-op between ticks
  task automatic side_request();
    int pick;
    pick = $urandom_range(0, 31);
    if (pick < 3) put_req(REQ_SEND, 1'($urandom), BYTE_W'($urandom));
    else if (pick < 6) put_req(REQ_RECV, 1'($urandom), BYTE_W'($urandom));
    else if (pick == 6) put_req(REQ_NOP, 1'($urandom), BYTE_W'($urandom));
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid and wait for every response to come back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Drive one serial frame on the receive line: start, data LSB first, stop
  task automatic rx_frame(input logic [BYTE_W-1:0] data, input int bit_len, input bit noisy,
                          input bit chatter);
    logic [9:0] frame_bits;
    logic       ln;
    frame_bits = {1'b1, data, 1'b0};
    for (int b = 0; b < 10; b++) begin
      for (int t = 0; t < bit_len; t++) begin
        ln = frame_bits[b];
        if (noisy && $urandom_range(0, 15) == 0) ln = ~ln;
        tick(ln);
        if (chatter) side_request();
      end
    end
  endtask

  // Mostly clean frames, plus short start pulses, line noise and idle line
  task automatic run_phase(input logic [CFG_DATA_W-1:0] per, input bit irq_on, input int n_items);
    int stop_at;
    int bit_len;
    int half;
    int pick;
    stop_at = item_cnt + n_items;
    bit_len = (per < 1) ? 1 : per;
    half    = (per / 2 < 1) ? 1 : per / 2;
    write_reg(CFG_BIT_PERIOD, per);
    write_reg(CFG_RX_IRQ_EN, {{(CFG_DATA_W-1){1'b0}}, irq_on});
    while (item_cnt < stop_at) begin
      idle_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        rx_frame(BYTE_W'($urandom), bit_len, pick == 0, 1'b1);
      end else if (pick < 15) begin
        // Low pulse ends before the start bit is sampled
        repeat ($urandom_range(1, half)) begin
          tick(1'b0);
          side_request();
        end
        repeat (2 * bit_len) begin
          tick(1'b1);
          side_request();
        end
      end else if (pick < 17) begin
        repeat ($urandom_range(1, 8)) begin
          tick(1'($urandom));
          side_request();
        end
        repeat (bit_len) tick(1'b1);
      end else begin
        repeat ($urandom_range(1, 2 * bit_len)) begin
          tick(1'b1);
          side_request();
        end
      end
    end
    settle();
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: empty receive, no-op, send, send while busy, a start
    put_req(REQ_RECV, 1'b0, 8'h00);
    put_req(REQ_NOP, 1'b1, 8'hFF);
    put_req(REQ_SEND, 1'b1, 8'hFF);
    put_req(REQ_SEND, 1'b0, 8'h00);
    tick(1'b0);
    tick(1'b1);
    settle();

    // Shortest legal period with the interrupt on
    write_reg(CFG_BIT_PERIOD, 16'd2);
    write_reg(CFG_RX_IRQ_EN, 16'd1);
    repeat (4) tick(1'b1);
    rx_frame(8'h00, 2, 1'b0, 1'b0);
    tick(1'b0);
    tick(1'b1);
    put_req(REQ_RECV, 1'b1, 8'h5A);
    put_req(REQ_RECV, 1'b0, 8'hA5);
    put_req(REQ_SEND, 1'b0, 8'h00);
    tick(1'b0);
    tick(1'b1);
    settle();

    // Periods that collapse to one tick
    run_phase(16'd0, 1'b0, 80);
    run_phase(16'd1, 1'b1, 80);

    // Longest period: frames only start, then the next phase shortens them
    write_reg(CFG_BIT_PERIOD, 16'hFFFF);
    write_reg(CFG_RX_IRQ_EN, 16'd0);
    put_req(REQ_SEND, 1'b1, BYTE_W'($urandom));
    repeat (300) begin
      tick(1'($urandom));
      side_request();
    end
    settle();

    for (int k = 0; k < RANDOM_PHASES; k++) begin
      run_phase(CFG_DATA_W'($urandom_range(2, 8)), 1'($urandom), PHASE_ITEMS);
    end

    // Back-to-back bad starts with no idling on either side
    idle_on  = 1'b0;
    stall_on = 1'b0;
    write_reg(CFG_BIT_PERIOD, 16'd2);
    write_reg(CFG_RX_IRQ_EN, 16'd1);
    repeat (40) tick(1'b1);
    put_req(REQ_RECV, 1'b0, 8'h00);
    for (int k = 0; k < BAD_START_PAIRS; k++) begin
      tick(1'b0);
      tick(1'b1);
      if (k % 16 == 0) put_req(REQ_SEND, 1'($urandom), BYTE_W'($urandom));
    end
    settle();
    repeat (6) @(negedge clk);

    if (fail_cnt == 0 && outstanding == 0) begin
      $display("[uart_8n1_transceiver_unit] OK");
    end else begin
      $display("[uart_8n1_transceiver_unit] ERROR");
    end
    $finish;
  end

endmodule
